FILE: rtl/core/erld_pkg.sv
package erld_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CntW     = 5;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned DictIdxW = 4;

  localparam logic [ByteW-1:0]   EscByte  = 8'h07;
  localparam logic [ByteW-1:0]   ZeroByte = 8'h00;
  localparam logic [CfgIdxW-1:0] CfgDictLo = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDictHi = 1'd1;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } in_req_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
  } out_req_t;

endpackage

FILE: rtl/core/erld_dict.sv
module erld_dict
  import erld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic [DictIdxW-1:0] idx_i,
  output logic [ByteW-1:0]    entry_o
);

  logic [CfgW-1:0] lo_q;
  logic [CfgW-1:0] hi_q;
  logic [CfgW-1:0] word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDictLo: lo_q <= cfg_wdata_i;
        CfgDictHi: hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign word    = idx_i[DictIdxW-1] ? hi_q : lo_q;
  assign entry_o = word[{idx_i[DictIdxW-2:0], 3'b000} +: ByteW];

endmodule

FILE: rtl/core/erld_seq.sv
module erld_seq
  import erld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_req_t             in_req_i,
  output logic [DictIdxW-1:0] dict_idx_o,
  input  logic [ByteW-1:0]    dict_entry_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_req_t            out_req_o
);

  logic             pend_q, pend_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [ByteW-1:0] nxt_q, nxt_d;
  logic             in_acc, out_acc;

  assign in_stall_o  = (rem_q != '0);
  assign out_valid_o = (rem_q != '0);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign dict_idx_o  = in_req_i.in_byte[DictIdxW-1:0];

  assign out_req_o.out_byte = byte_q;
  assign out_req_o.run_last = (rem_q == CntW'(1));

  always_comb begin
    pend_d = pend_q;
    rem_d  = rem_q;
    byte_d = byte_q;
    nxt_d  = nxt_q;
    if (out_acc) begin
      // shared down-counter steps one byte of the run
      rem_d  = rem_q - CntW'(1);
      byte_d = nxt_q;
    end
    if (in_acc) begin
      if (pend_q) begin
        pend_d = 1'b0;
        if (in_req_i.in_byte == ZeroByte) begin
          rem_d  = CntW'(2);
          byte_d = EscByte;
          nxt_d  = ZeroByte;
        end else begin
          rem_d  = CntW'(in_req_i.in_byte[ByteW-1:DictIdxW]);
          byte_d = dict_entry_i;
          nxt_d  = dict_entry_i;
        end
      end else if (in_req_i.in_byte == EscByte && !in_req_i.in_last) begin
        pend_d = 1'b1;
      end else begin
        rem_d  = CntW'(1);
        byte_d = in_req_i.in_byte;
        nxt_d  = in_req_i.in_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      pend_q <= pend_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    nxt_q  <= nxt_d;
  end

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_req_o.run_last |=> !out_valid_o)
    else $error("run continued after last byte");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_req_o.run_last |=> out_valid_o)
    else $error("run ended early");

  a_esc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && pend_q && in_req_i.in_byte == ZeroByte |=>
    out_valid_o && out_req_o.out_byte == EscByte && !out_req_o.run_last)
    else $error("escaped zero not expanded");

  a_esc_sets_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !pend_q && in_req_i.in_byte == EscByte && !in_req_i.in_last |=>
    pend_q && !out_valid_o)
    else $error("escape not held pending");

endmodule

FILE: rtl/core/escape_run_length_decoder.sv
// The first output byte is registered the cycle after its request is taken. One
// byte per cycle goes out while out_stall_i is low; a run stalls the input until
// its last byte is taken (shared run down-counter). A non-last escape is held pending.
// Reset (rst_ni low, async): dictionary words clear to zero, no escape pending,
// output empty.
module escape_run_length_decoder
  import erld_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_req_t            in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_req_t           out_req_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  logic [DictIdxW-1:0] dict_idx;
  logic [ByteW-1:0]    dict_entry;

  erld_dict u_dict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .idx_i       (dict_idx),
    .entry_o     (dict_entry)
  );

  erld_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .dict_idx_o   (dict_idx),
    .dict_entry_i (dict_entry),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_req_o    (out_req_o)
  );

endmodule

FILE: tb/escape_run_length_decoder_test.sv
`timescale 1ns / 100ps

module escape_run_length_decoder_test;
  import erld_pkg::*;

  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned RandItems   = 18;
  localparam int unsigned NumRows     = 24;

  typedef struct packed {
    in_req_t    req;
    logic       typed;
    logic [1:0] n_res;
    out_req_t   res_a;
    out_req_t   res_b;
  } dir_row_t;

  localparam out_req_t NoRes = '0;

  // typed = 0: expectation comes from the decoder model below
  localparam dir_row_t DirRows [NumRows] = '{
    '{'{8'h00, 1'b0},    1'b1, 2'd1, '{8'h00, 1'b1},   NoRes},
    '{'{8'hff, 1'b0},    1'b1, 2'd1, '{8'hff, 1'b1},   NoRes},
    '{'{8'hff, 1'b1},    1'b1, 2'd1, '{8'hff, 1'b1},   NoRes},
    '{'{EscByte, 1'b1},  1'b1, 2'd1, '{EscByte, 1'b1}, NoRes},
    '{'{EscByte, 1'b0},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{ZeroByte, 1'b0}, 1'b1, 2'd2, '{EscByte, 1'b0}, '{ZeroByte, 1'b1}},
    '{'{EscByte, 1'b0},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{8'hf0, 1'b0},    1'b0, 2'd0, NoRes,            NoRes},
    '{'{EscByte, 1'b0},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{8'hff, 1'b1},    1'b0, 2'd0, NoRes,            NoRes},
    '{'{EscByte, 1'b0},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{EscByte, 1'b0},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{EscByte, 1'b0},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{8'h0f, 1'b0},    1'b1, 2'd0, NoRes,            NoRes},
    '{'{EscByte, 1'b0},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{8'h1a, 1'b0},    1'b0, 2'd0, NoRes,            NoRes},
    '{'{EscByte, 1'b0},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{ZeroByte, 1'b1}, 1'b1, 2'd2, '{EscByte, 1'b0}, '{ZeroByte, 1'b1}},
    '{'{EscByte, 1'b0},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{EscByte, 1'b1},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{8'h41, 1'b1},    1'b1, 2'd1, '{8'h41, 1'b1},   NoRes},
    '{'{EscByte, 1'b0},  1'b1, 2'd0, NoRes,            NoRes},
    '{'{8'h85, 1'b0},    1'b0, 2'd0, NoRes,            NoRes},
    '{'{8'haa, 1'b1},    1'b1, 2'd1, '{8'haa, 1'b1},   NoRes}
  };

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  in_req_t           in_req    = '0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_req_t          out_req;
  logic              cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx  = CfgDictLo;
  logic [CfgW-1:0]   cfg_wdata = '0;

  logic [CfgW-1:0]   dict_lo   = '0;
  logic [CfgW-1:0]   dict_hi   = '0;
  logic              esc_armed = 1'b0;
  out_req_t          run_bytes[$];
  out_req_t          expected_bytes[$];
  out_req_t          want_res;

  int unsigned       tx_idle_pct  = 0;
  int unsigned       rx_stall_pct = 0;
  bit                hold_req     = 1'b0;
  int unsigned       hold_left    = 0;
  int unsigned       mismatches   = 0;
  int unsigned       cycles       = 0;

  escape_run_length_decoder u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void decode_byte(input in_req_t r);
    logic [3:0] run_len;
    logic [3:0] slot;
    logic [7:0] entry;
    run_bytes.delete();
    if (esc_armed) begin
      esc_armed = 1'b0;
      if (r.in_byte == ZeroByte) begin
        run_bytes.push_back(out_req_t'{EscByte, 1'b0});
        run_bytes.push_back(out_req_t'{ZeroByte, 1'b1});
      end else begin
        run_len = r.in_byte[7:4];
        slot    = r.in_byte[DictIdxW-1:0];
        entry   = slot[3] ? dict_hi[slot[2:0]*8 +: 8] : dict_lo[slot[2:0]*8 +: 8];
        for (int k = 0; k < run_len; k++) begin
          run_bytes.push_back(out_req_t'{entry, k == run_len - 1});
        end
      end
    end else if (r.in_byte == EscByte && !r.in_last) begin
      esc_armed = 1'b1;
    end else begin
      run_bytes.push_back(out_req_t'{r.in_byte, 1'b1});
    end
  endfunction

  task automatic send_req(input dir_row_t row);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_req   <= row.req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_byte(row.req);
    if (row.typed) begin
      if (row.n_res > 0) expected_bytes.push_back(row.res_a);
      if (row.n_res > 1) expected_bytes.push_back(row.res_b);
    end else begin
      foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
    end
  endtask

  // mostly escape/operand pairs with random content; some dangling escapes
  task automatic send_random(input int n_items);
    dir_row_t row;
    int       sent;
    int       pick;
    row  = '0;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      row.req.in_last = ($urandom_range(0, 9) == 0);
      if (pick < 45) begin
        row.req.in_byte = 8'($urandom_range(0, 255));
        send_req(row);
        sent++;
      end else if (pick < 85) begin
        row.req = '{EscByte, 1'b0};
        send_req(row);
        pick = $urandom_range(0, 9);
        row.req.in_byte = (pick == 0) ? ZeroByte :
                          (pick == 1) ? EscByte : 8'($urandom_range(0, 255));
        row.req.in_last = ($urandom_range(0, 9) == 0);
        send_req(row);
        sent += 2;
      end else if (pick < 92) begin
        row.req = '{EscByte, 1'b1};
        send_req(row);
        sent++;
      end else begin
        row.req = '{EscByte, 1'b0};
        send_req(row);
        sent++;
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_dict(input logic [CfgW-1:0] lo, input logic [CfgW-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgDictLo;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx   <= CfgDictHi;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dict_lo = lo;
    dict_hi = hi;
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected request: out_byte %02h run_last %0b",
               out_req.out_byte, out_req.run_last);
        mismatches++;
      end else begin
        want_res = expected_bytes.pop_front();
        if (out_req.out_byte !== want_res.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want_res.out_byte, out_req.out_byte);
          mismatches++;
        end
        if (out_req.run_last !== want_res.run_last) begin
          $error("run_last: expected %0b, got %0b", want_res.run_last, out_req.run_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** escape_run_length_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_dict(64'hf7e6_d5c4_b3a2_9180, 64'h0f1e_2d3c_4b5a_6978);
    for (int i = 0; i < NumRows; i++) send_req(DirRows[i]);
    settle();

    load_dict('1, '1);
    send_random(RandItems);
    settle();

    load_dict({$urandom, $urandom}, {$urandom, $urandom});
    tx_idle_pct = 63;
    send_random(RandItems / 2);
    settle();
    send_random(RandItems / 2);
    settle();

    load_dict('0, '0);
    tx_idle_pct  = 0;
    rx_stall_pct = 63;
    send_random(RandItems);
    settle();

    load_dict({$urandom, $urandom}, {$urandom, $urandom});
    tx_idle_pct  = 10;
    rx_stall_pct = 10;
    send_random(RandItems);
    settle();

    // long receiver hold-off with the sender flat out
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b1;
    send_random(RandItems);
    settle();

    if (mismatches == 0) begin
      $display("** escape_run_length_decoder: PASSED **");
    end else begin
      $display("** escape_run_length_decoder: FAILED **");
    end
    $finish;
  end

endmodule
